[hw/rtl/scc_pkg.sv]
package scc_pkg;

    localparam int SLOTS_DEF      = 32;
    localparam int READ_AHEAD_DEF = 1;

    // request codes
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // result codes
    localparam logic [1:0] K_FILL      = 2'd0;
    localparam logic [1:0] K_WRITEBACK = 2'd1;
    localparam logic [1:0] K_ACCESS    = 2'd2;
    localparam logic [1:0] K_FLUSHED   = 2'd3;

    // configuration register indexes
    localparam logic REG_DEVICE_SECTORS = 1'b0;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] sector;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] target_sector;
        logic [5:0]  slot;
        logic        was_hit;
        logic        last;
    } t_rsp;

    // sequencer to output stage
    typedef struct packed {
        logic valid;
        logic fin;
        t_rsp rsp;
    } t_push;

    // output stage to sequencer
    typedef struct packed {
        logic can_push;
        logic pend_empty;
    } t_oq_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_VWB,
        S_FILL,
        S_USE,
        S_FL_SCAN,
        S_FL_WB,
        S_FIN
    } t_state;

endpackage

[hw/rtl/scc_ram.sv]
module scc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/scc_outq.sv]
module scc_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scc_pkg::t_push    i_push,
    output scc_pkg::t_oq_stat o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output scc_pkg::t_rsp     o_data
);

    logic          r_out_v, n_out_v;
    logic          r_pend_v, n_pend_v;
    scc_pkg::t_rsp r_out, n_out;
    scc_pkg::t_rsp r_pend, n_pend;
    logic          out_free;

    assign out_free          = !r_out_v || i_ready;
    assign o_stat.can_push   = !r_pend_v || out_free;
    assign o_stat.pend_empty = !r_pend_v;

    // hold one result back until it is known whether it ends the request
    always_comb begin
        n_out_v  = r_out_v;
        n_pend_v = r_pend_v;
        n_out    = r_out;
        n_pend   = r_pend;
        if (r_out_v && i_ready) begin
            n_out_v = 1'b0;
        end
        if (i_push.valid) begin
            if (r_pend_v) begin
                n_out      = r_pend;
                n_out.last = 1'b0;
                n_out_v    = 1'b1;
            end
            n_pend   = i_push.rsp;
            n_pend_v = 1'b1;
        end else if (i_push.fin && r_pend_v && out_free) begin
            n_out      = r_pend;
            n_out.last = 1'b1;
            n_out_v    = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // never push over a held result that cannot move on
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid && r_pend_v |-> out_free)
        else $error("result pushed while output full");

    // the last result of a request leaves only on finish
    a_last_on_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.fin && r_pend_v && out_free && !i_push.valid |=> r_out_v && r_out.last)
        else $error("final result not marked last");

endmodule

[hw/rtl/scc_ctrl.sv]
module scc_ctrl #(
    parameter int SLOTS      = scc_pkg::SLOTS_DEF,
    parameter int READ_AHEAD = scc_pkg::READ_AHEAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_dev,
    input  logic              i_valid,
    output logic              o_ready,
    input  scc_pkg::t_req     i_req,
    output scc_pkg::t_push    o_push,
    input  scc_pkg::t_oq_stat i_stat
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(READ_AHEAD + 2);

    scc_pkg::t_state r_state, n_state;
    logic [1:0]      r_act, n_act;
    logic [31:0]     r_sec, n_sec;
    logic [31:0]     r_cur, n_cur;
    logic [AW-1:0]   r_ahead, n_ahead;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_cmp_v, n_cmp_v;
    logic [SW-1:0]   r_cmp_idx, n_cmp_idx;
    logic [SW-1:0]   r_slot, n_slot;
    logic            r_hit, n_hit;
    logic [CW-1:0]   r_filled, n_filled;
    logic [SW-1:0]   r_hand, n_hand;
    logic [SLOTS-1:0] r_dirty, n_dirty;
    logic [SLOTS-1:0] r_acc, n_acc;

    logic          ram_we, ram_re;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata;
    logic [SW-1:0] hand_next;
    logic [32:0]   nx;

    scc_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_tags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cur),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign hand_next = (r_hand == SW'(SLOTS - 1)) ? '0 : r_hand + 1'b1;
    assign nx        = {1'b0, r_sec} + 33'(r_ahead) + 33'd1;

    // sequencer: lookup, sweep, victim writeback, fill, access, read-ahead, flush
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_sec     = r_sec;
        n_cur     = r_cur;
        n_ahead   = r_ahead;
        n_idx     = r_idx;
        n_cmp_v   = r_cmp_v;
        n_cmp_idx = r_cmp_idx;
        n_slot    = r_slot;
        n_hit     = r_hit;
        n_filled  = r_filled;
        n_hand    = r_hand;
        n_dirty   = r_dirty;
        n_acc     = r_acc;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_re    = 1'b0;
        ram_raddr = r_idx[SW-1:0];
        o_ready   = 1'b0;
        o_push    = '0;
        unique case (r_state)
            scc_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_act   = i_req.action;
                    n_sec   = i_req.sector;
                    n_cur   = i_req.sector;
                    n_ahead = '0;
                    n_idx   = '0;
                    n_cmp_v = 1'b0;
                    unique case (i_req.action) inside
                        scc_pkg::ACT_READ, scc_pkg::ACT_WRITE: n_state = scc_pkg::S_LOOK;
                        scc_pkg::ACT_FLUSH:                    n_state = scc_pkg::S_FL_SCAN;
                        default:                               n_state = scc_pkg::S_IDLE;
                    endcase
                end
            end
            scc_pkg::S_LOOK: begin
                // one tag read per cycle, compared the cycle after
                if (r_cmp_v && ram_rdata == r_cur) begin
                    n_slot  = r_cmp_idx;
                    n_hit   = 1'b1;
                    n_state = scc_pkg::S_USE;
                end else if (r_idx < r_filled) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[SW-1:0];
                    n_cmp_idx = r_idx[SW-1:0];
                    n_cmp_v   = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_hit = 1'b0;
                    if (r_filled < CW'(SLOTS)) begin
                        n_slot   = r_filled[SW-1:0];
                        n_filled = r_filled + 1'b1;
                        n_state  = scc_pkg::S_FILL;
                    end else begin
                        n_state = scc_pkg::S_SWEEP;
                    end
                end
            end
            scc_pkg::S_SWEEP: begin
                // clear marks until an unmarked slot comes under the hand
                n_hand = hand_next;
                if (r_acc[r_hand]) begin
                    n_acc[r_hand] = 1'b0;
                end else begin
                    n_slot = r_hand;
                    if (r_dirty[r_hand]) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_hand;
                        n_state   = scc_pkg::S_VWB;
                    end else begin
                        n_state = scc_pkg::S_FILL;
                    end
                end
            end
            scc_pkg::S_VWB: begin
                if (i_stat.can_push) begin
                    o_push.valid             = 1'b1;
                    o_push.rsp.kind          = scc_pkg::K_WRITEBACK;
                    o_push.rsp.target_sector = ram_rdata;
                    o_push.rsp.slot          = 6'(r_slot);
                    n_state                  = scc_pkg::S_FILL;
                end
            end
            scc_pkg::S_FILL: begin
                if (i_stat.can_push) begin
                    o_push.valid             = 1'b1;
                    o_push.rsp.kind          = scc_pkg::K_FILL;
                    o_push.rsp.target_sector = r_cur;
                    o_push.rsp.slot          = 6'(r_slot);
                    ram_we                   = 1'b1;
                    ram_waddr                = r_slot;
                    n_dirty[r_slot]          = 1'b0;
                    n_state                  = scc_pkg::S_USE;
                end
            end
            scc_pkg::S_USE: begin
                n_acc[r_slot] = 1'b1;
                if (r_ahead == '0) begin
                    if (r_act == scc_pkg::ACT_WRITE) begin
                        n_dirty[r_slot] = 1'b1;
                    end
                    if (i_stat.can_push) begin
                        o_push.valid             = 1'b1;
                        o_push.rsp.kind          = scc_pkg::K_ACCESS;
                        o_push.rsp.target_sector = r_sec;
                        o_push.rsp.slot          = 6'(r_slot);
                        o_push.rsp.was_hit       = r_hit;
                    end
                end
                if (r_ahead != '0 || i_stat.can_push) begin
                    // advance to the next read-ahead sector or finish
                    if (r_act == scc_pkg::ACT_READ && r_ahead < AW'(READ_AHEAD)
                            && nx < {1'b0, i_dev}) begin
                        n_cur   = nx[31:0];
                        n_ahead = r_ahead + 1'b1;
                        n_idx   = '0;
                        n_cmp_v = 1'b0;
                        n_state = scc_pkg::S_LOOK;
                    end else begin
                        n_state = scc_pkg::S_FIN;
                    end
                end
            end
            scc_pkg::S_FL_SCAN: begin
                if (r_idx < r_filled) begin
                    if (r_dirty[r_idx[SW-1:0]]) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx[SW-1:0];
                        n_state   = scc_pkg::S_FL_WB;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (i_stat.can_push) begin
                    o_push.valid    = 1'b1;
                    o_push.rsp.kind = scc_pkg::K_FLUSHED;
                    n_state         = scc_pkg::S_FIN;
                end
            end
            scc_pkg::S_FL_WB: begin
                if (i_stat.can_push) begin
                    o_push.valid              = 1'b1;
                    o_push.rsp.kind           = scc_pkg::K_WRITEBACK;
                    o_push.rsp.target_sector  = ram_rdata;
                    o_push.rsp.slot           = 6'(r_idx[SW-1:0]);
                    n_dirty[r_idx[SW-1:0]]    = 1'b0;
                    n_idx                     = r_idx + 1'b1;
                    n_state                   = scc_pkg::S_FL_SCAN;
                end
            end
            scc_pkg::S_FIN: begin
                o_push.fin = 1'b1;
                if (i_stat.pend_empty) begin
                    n_state = scc_pkg::S_IDLE;
                end
            end
            default: n_state = scc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= scc_pkg::S_IDLE;
            r_filled <= '0;
            r_hand   <= '0;
            r_dirty  <= '0;
            r_acc    <= '0;
            r_cmp_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_hand   <= n_hand;
            r_dirty  <= n_dirty;
            r_acc    <= n_acc;
            r_cmp_v  <= n_cmp_v;
        end
        r_act     <= n_act;
        r_sec     <= n_sec;
        r_cur     <= n_cur;
        r_ahead   <= n_ahead;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
        r_hit     <= n_hit;
    end

    a_filled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CW'(SLOTS))
        else $error("fill count beyond slot count");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_hand} < (SW+1)'(SLOTS))
        else $error("clock hand out of ring");

    a_dirty_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == scc_pkg::S_FL_WB |-> r_idx < r_filled)
        else $error("flush writeback of unfilled slot");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == scc_pkg::S_IDLE |-> i_stat.pend_empty)
        else $error("result held back while idle");

endmodule

[hw/rtl/sector_cache_clock_controller_unit.sv]
// Sector cache tag and replacement controller. Each request is taken one
// at a time and the input stays not-ready until its last result has left the
// held-back stage. Tag lookup reads one tag per cycle from the tag RAM and
// compares it against the filled slots; on a full cache the clock hand sweeps
// for a victim, and each read-ahead sector gets its own lookup. A flush scans
// the filled slots and writes back each dirty one. device_sectors sits at byte
// address 0 of the APB port. The tag RAM is not cleared: only filled slots
// are read.
module sector_cache_clock_controller_unit #(
    parameter int SLOTS      = scc_pkg::SLOTS_DEF,
    parameter int READ_AHEAD = scc_pkg::READ_AHEAD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  scc_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output scc_pkg::t_rsp o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic              dev_sel;
    logic [31:0]       r_dev_sectors;
    scc_pkg::t_push    push;
    scc_pkg::t_oq_stat stat;

    assign pready = 1'b1;

    // configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_sectors <= '0;
        end else if (psel && penable && pwrite && dev_sel) begin
            r_dev_sectors <= pwdata;
        end
    end

    assign dev_sel = (paddr[2] == scc_pkg::REG_DEVICE_SECTORS) && (paddr[1:0] == 2'b00);
    assign prdata  = dev_sel ? r_dev_sectors : '0;

    scc_ctrl #(.SLOTS(SLOTS), .READ_AHEAD(READ_AHEAD)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dev   (r_dev_sectors),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_data),
        .o_push  (push),
        .i_stat  (stat)
    );

    scc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stat  (stat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[tb/scc_checker.sv]
module scc_checker #(
    parameter int SLOTS      = 32,
    parameter int READ_AHEAD = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  scc_pkg::t_req i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  scc_pkg::t_rsp i_out_data,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    output int            o_errors,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import scc_pkg::*;

    logic [31:0] dev_sectors;
    logic [31:0] tag_q [SLOTS];
    logic        dirty_q [SLOTS];
    logic        used_q [SLOTS];
    int          hand;
    int          filled;
    t_rsp        cmd_q [$];
    t_rsp        req_cmds [$];

    assign o_pending = cmd_q.size();

    function automatic int find_slot(logic [31:0] sec);
        for (int i = 0; i < filled; i++)
            if (tag_q[i] == sec) return i;
        return -1;
    endfunction

    function automatic t_rsp mk(logic [1:0] k, logic [31:0] t, int s, logic h);
        t_rsp r;
        r.kind = k;
        r.target_sector = t;
        r.slot = 6'(s);
        r.was_hit = h;
        r.last = 1'b0;
        return r;
    endfunction

    // claim a free slot or sweep the clock hand for a victim
    task automatic claim_slot(logic [31:0] sec, output int s);
        if (filled < SLOTS) begin
            s = filled;
            filled++;
        end else begin
            while (used_q[hand]) begin
                used_q[hand] = 1'b0;
                hand = (hand + 1) % SLOTS;
            end
            s = hand;
            hand = (hand + 1) % SLOTS;
            if (dirty_q[s]) req_cmds.push_back(mk(K_WRITEBACK, tag_q[s], s, 1'b0));
        end
        req_cmds.push_back(mk(K_FILL, sec, s, 1'b0));
        tag_q[s] = sec;
        dirty_q[s] = 1'b0;
    endtask

    task automatic predict_request(t_req rq);
        int s;
        int hit;
        logic [32:0] nx;
        req_cmds.delete();
        if (rq.action == ACT_READ || rq.action == ACT_WRITE) begin
            hit = find_slot(rq.sector);
            if (hit < 0) claim_slot(rq.sector, s);
            else s = hit;
            used_q[s] = 1'b1;
            if (rq.action == ACT_WRITE) dirty_q[s] = 1'b1;
            req_cmds.push_back(mk(K_ACCESS, rq.sector, s, hit >= 0));
            if (rq.action == ACT_READ) begin
                for (int i = 1; i <= READ_AHEAD; i++) begin
                    nx = {1'b0, rq.sector} + 33'(i);
                    if (nx >= {1'b0, dev_sectors}) break;
                    hit = find_slot(nx[31:0]);
                    if (hit < 0) claim_slot(nx[31:0], s);
                    else s = hit;
                    used_q[s] = 1'b1;
                end
            end
        end else if (rq.action == ACT_FLUSH) begin
            for (int i = 0; i < filled; i++)
                if (dirty_q[i]) begin
                    req_cmds.push_back(mk(K_WRITEBACK, tag_q[i], i, 1'b0));
                    dirty_q[i] = 1'b0;
                end
            req_cmds.push_back(mk(K_FLUSHED, 32'd0, 0, 1'b0));
        end
        if (req_cmds.size() > 0) req_cmds[req_cmds.size() - 1].last = 1'b1;
        foreach (req_cmds[i]) cmd_q.push_back(req_cmds[i]);
    endtask

    // track state, predict accepted transactions, compare results
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            dev_sectors = '0;
            hand = 0;
            filled = 0;
            o_errors = 0;
            for (int i = 0; i < SLOTS; i++) begin
                dirty_q[i] = 1'b0;
                used_q[i] = 1'b0;
            end
            cmd_q.delete();
        end else begin
            if (i_cfg_we) dev_sectors = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_request(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (cmd_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result %p", i_out_data);
                end else begin
                    want = cmd_q.pop_front();
                    if (want !== i_out_data) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected %p actual %p", want, i_out_data);
                    end
                end
            end
        end
    end
endmodule

[tb/tb_sector_cache_clock_controller_unit.sv]
module tb_sector_cache_clock_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import scc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_rsp        o_out_data;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          cycles;
    logic        hold_off;
    logic [31:0] hot_base;

    sector_cache_clock_controller_unit dut (.*);

    scc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .i_cfg_we(psel && penable && pwrite && pready), .i_cfg_data(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // abort on a runaway run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        int n;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                for (int i = 0; i < 300; i++) @(negedge i_clk);
                hold_off = 1'b0;
            end
            n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v; penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send(logic [1:0] a, logic [31:0] s);
        repeat (gap_len()) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= '{action: a, sector: s};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_req();
        int p;
        logic [1:0] a;
        logic [31:0] s;
        p = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) < 5) ? ACT_READ : ACT_WRITE;
        if (p < 4) a = ACT_FLUSH;
        else if (p < 6) a = ACT_UNUSED;
        if (p < 70) s = hot_base + 32'($urandom_range(0, 47));
        else s = $urandom;
        send(a, s);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cycles = 0;
        hold_off = 1'b0;
        hot_base = 32'd100;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (200) @(posedge i_clk);

        // directed: device end, top sectors, reserved action, flush
        cfg_write(32'd10);
        send(ACT_READ, 32'd0);
        send(ACT_READ, 32'd9);
        send(ACT_READ, 32'd10);
        send(ACT_WRITE, 32'hFFFF_FFFF);
        send(ACT_READ, 32'hFFFF_FFFF);
        send(ACT_UNUSED, 32'h5555_AAAA);
        send(ACT_WRITE, 32'd0);
        send(ACT_READ, 32'd8);
        send(ACT_FLUSH, 32'hAAAA_5555);
        send(ACT_FLUSH, 32'd0);
        drain();
        cfg_write(32'hFFFF_FFFF);
        send(ACT_READ, 32'hFFFF_FFFE);
        send(ACT_READ, 32'hFFFF_FFFF);
        for (int i = 0; i < 40; i++) send(ACT_WRITE, 32'd1000 + 32'(i));
        send(ACT_FLUSH, 32'd0);
        drain();
        cfg_write(32'd0);
        send(ACT_READ, 32'd5);
        drain();

        // random phases across several device sizes
        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(ph == 0 ? 32'hFFFF_FFFF : $urandom);
            hot_base = (ph == 3) ? 32'hFFFF_FFE0 : $urandom_range(0, 1000);
            if (ph == 1) hold_off = 1'b1;
            for (int i = 0; i < 52; i++) random_req();
            drain();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/scc_pkg.sv
hw/rtl/scc_ram.sv
hw/rtl/scc_outq.sv
hw/rtl/scc_ctrl.sv
hw/rtl/sector_cache_clock_controller_unit.sv
tb/scc_checker.sv
tb/tb_sector_cache_clock_controller_unit.sv
